// File: hdl/jia_pkg.sv
// Shared types and codes for the Java-style integer ALU.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package jia_pkg;

  localparam int unsigned DivSteps = 64;

  typedef enum logic [5:0] {
    CMD_PASS  = 6'd0,  CMD_INEG  = 6'd1,  CMD_INOT  = 6'd2,  CMD_BNOT  = 6'd3,
    CMD_TZERO = 6'd4,  CMD_LNEG  = 6'd5,  CMD_LNOT  = 6'd6,  CMD_BAND  = 6'd7,
    CMD_BOR   = 6'd8,  CMD_IADD  = 6'd9,  CMD_ISUB  = 6'd10, CMD_IMUL  = 6'd11,
    CMD_IDIV  = 6'd12, CMD_IREM  = 6'd13, CMD_IAND  = 6'd14, CMD_IOR   = 6'd15,
    CMD_IXOR  = 6'd16, CMD_ISHL  = 6'd17, CMD_ISHR  = 6'd18, CMD_IUSHR = 6'd19,
    CMD_EQ    = 6'd20, CMD_NE    = 6'd21, CMD_LT    = 6'd22, CMD_GT    = 6'd23,
    CMD_LE    = 6'd24, CMD_GE    = 6'd25, CMD_LADD  = 6'd26, CMD_LSUB  = 6'd27,
    CMD_LMUL  = 6'd28, CMD_LDIV  = 6'd29, CMD_LREM  = 6'd30, CMD_LAND  = 6'd31,
    CMD_LOR   = 6'd32, CMD_LXOR  = 6'd33, CMD_LSHL  = 6'd34, CMD_LSHR  = 6'd35,
    CMD_LUSHR = 6'd36
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_INT  = 2'd0,
    KIND_LONG = 2'd1,
    KIND_BOOL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADOP = 2'd1,
    ST_DIV0  = 2'd2
  } status_e;

  typedef struct packed {
    logic [5:0]         cmd;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         kind;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [63:0] value;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        neg_q;
    logic        neg_r;
    logic [63:0] rem;
    logic [63:0] dvd;
    logic [63:0] dsr;
  } pipe_t;

endpackage
`default_nettype wire

// File: hdl/jia_div_stage.sv
// One registered step of the restoring divider; develops one quotient bit.
// Depends on jia_pkg for the pipeline beat type.
`timescale 1ns / 1ps
`default_nettype none
module jia_div_stage import jia_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire pipe_t data_i,
  output logic       valid_o,
  output pipe_t      data_o
);

  logic  valid_q;
  pipe_t data_d, data_q;
  logic [64:0] trial;
  logic        ge;

  always_comb begin
    trial  = {data_i.rem, data_i.dvd[63]};
    ge     = trial >= {1'b0, data_i.dsr};
    data_d = data_i;
    data_d.dvd = {data_i.dvd[62:0], ge};
    if (ge) begin
      data_d.rem = 64'(trial - {1'b0, data_i.dsr});
    end else begin
      data_d.rem = trial[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// File: hdl/java_integer_alu_core.sv
// Top level of the Java-style int, long and boolean ALU.
// Depends on jia_pkg and jia_div_stage.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (cmd, operand_a, operand_b)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (value, kind, status)
//
// Every beat passes through decode and partial products, product sum,
// 64 divider steps (one quotient bit each), and the result register.
// One beat enters per cycle while the output is not stalled; the whole pipeline advances together.
// A stall at the output freezes every stage, so nothing is lost or repeated.
// Reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module java_integer_alu_core import jia_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: decode, simple results, divider setup, partial products.
  pipe_t s1_d, s1_q;
  logic  s1_valid_q;
  logic [63:0] p_ll_d, p_ll_q;
  logic [31:0] p_x_d, p_x_q;
  logic [63:0] a, b, da, db;
  logic [31:0] a32, b32;
  logic [4:0]  s5;
  logic [5:0]  s6;
  logic        is_long_div;
  logic [31:0] p_lh, p_hl;

  always_comb begin
    a   = in_data_i.operand_a;
    b   = in_data_i.operand_b;
    a32 = a[31:0];
    b32 = b[31:0];
    s5  = b[4:0];
    s6  = b[5:0];
    p_ll_d = 64'(a32 * b32);
    p_lh   = 32'(a32 * b[63:32]);
    p_hl   = 32'(a[63:32] * b32);
    p_x_d  = 32'(p_lh + p_hl);
    is_long_div = (in_data_i.cmd == CMD_LDIV) || (in_data_i.cmd == CMD_LREM);
    da = is_long_div ? a : {{32{a32[31]}}, a32};
    db = is_long_div ? b : {{32{b32[31]}}, b32};

    s1_d        = '0;
    s1_d.cmd    = in_data_i.cmd;
    s1_d.kind   = KIND_INT;
    s1_d.status = ST_OK;
    s1_d.neg_q  = da[63] ^ db[63];
    s1_d.neg_r  = da[63];
    s1_d.dvd    = da[63] ? 64'(-da) : da;
    s1_d.dsr    = db[63] ? 64'(-db) : db;
    s1_d.rem    = '0;

    unique case (cmd_e'(in_data_i.cmd))
      CMD_PASS:  begin s1_d.value = a; s1_d.kind = KIND_LONG; end
      CMD_INEG:  s1_d.value = {{32{1'b0}}, 32'(-a32)};
      CMD_INOT:  s1_d.value = {{32{1'b0}}, ~a32};
      CMD_BNOT, CMD_TZERO: begin
        s1_d.value = 64'(a32 == '0); s1_d.kind = KIND_BOOL;
      end
      CMD_LNEG:  begin s1_d.value = 64'(-a); s1_d.kind = KIND_LONG; end
      CMD_LNOT:  begin s1_d.value = ~a; s1_d.kind = KIND_LONG; end
      CMD_BAND:  begin
        s1_d.value = 64'((a32 != '0) && (b32 != '0)); s1_d.kind = KIND_BOOL;
      end
      CMD_BOR:   begin
        s1_d.value = 64'((a32 != '0) || (b32 != '0)); s1_d.kind = KIND_BOOL;
      end
      CMD_IADD:  s1_d.value = {{32{1'b0}}, 32'(a32 + b32)};
      CMD_ISUB:  s1_d.value = {{32{1'b0}}, 32'(a32 - b32)};
      CMD_IMUL:  s1_d.value = '0;
      CMD_IDIV, CMD_IREM: begin
        if (b32 == '0) s1_d.status = ST_DIV0;
      end
      CMD_IAND:  s1_d.value = {{32{1'b0}}, a32 & b32};
      CMD_IOR:   s1_d.value = {{32{1'b0}}, a32 | b32};
      CMD_IXOR:  s1_d.value = {{32{1'b0}}, a32 ^ b32};
      CMD_ISHL:  s1_d.value = {{32{1'b0}}, a32 << s5};
      CMD_ISHR:  s1_d.value = {{32{1'b0}}, 32'($signed(a32) >>> s5)};
      CMD_IUSHR: s1_d.value = {{32{1'b0}}, a32 >> s5};
      CMD_EQ:    begin s1_d.value = 64'(a32 == b32); s1_d.kind = KIND_BOOL; end
      CMD_NE:    begin s1_d.value = 64'(a32 != b32); s1_d.kind = KIND_BOOL; end
      CMD_LT:    begin
        s1_d.value = 64'($signed(a32) < $signed(b32)); s1_d.kind = KIND_BOOL;
      end
      CMD_GT:    begin
        s1_d.value = 64'($signed(a32) > $signed(b32)); s1_d.kind = KIND_BOOL;
      end
      CMD_LE:    begin
        s1_d.value = 64'($signed(a32) <= $signed(b32)); s1_d.kind = KIND_BOOL;
      end
      CMD_GE:    begin
        s1_d.value = 64'($signed(a32) >= $signed(b32)); s1_d.kind = KIND_BOOL;
      end
      CMD_LADD:  begin s1_d.value = 64'(a + b); s1_d.kind = KIND_LONG; end
      CMD_LSUB:  begin s1_d.value = 64'(a - b); s1_d.kind = KIND_LONG; end
      CMD_LMUL:  s1_d.kind = KIND_LONG;
      CMD_LDIV, CMD_LREM: begin
        s1_d.kind = KIND_LONG;
        if (b == '0) s1_d.status = ST_DIV0;
      end
      CMD_LAND:  begin s1_d.value = a & b; s1_d.kind = KIND_LONG; end
      CMD_LOR:   begin s1_d.value = a | b; s1_d.kind = KIND_LONG; end
      CMD_LXOR:  begin s1_d.value = a ^ b; s1_d.kind = KIND_LONG; end
      CMD_LSHL:  begin s1_d.value = a << s6; s1_d.kind = KIND_LONG; end
      CMD_LSHR:  begin
        s1_d.value = 64'($signed(a) >>> s6); s1_d.kind = KIND_LONG;
      end
      CMD_LUSHR: begin s1_d.value = a >> s6; s1_d.kind = KIND_LONG; end
      default:   s1_d.status = ST_BADOP;
    endcase
  end

  // Stage 2: sum of the partial products.
  pipe_t s2_d, s2_q;
  logic  s2_valid_q;

  always_comb begin
    s2_d = s1_q;
    if (s1_q.cmd == CMD_IMUL) begin
      s2_d.value = {{32{1'b0}}, p_ll_q[31:0]};
    end else if (s1_q.cmd == CMD_LMUL) begin
      s2_d.value = 64'(p_ll_q + {p_x_q, 32'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s1_d;
      p_ll_q <= p_ll_d;
      p_x_q  <= p_x_d;
      s2_q   <= s2_d;
    end
  end

  // Divider chain.
  pipe_t chain_data  [DivSteps+1];
  logic  chain_valid [DivSteps+1];
  assign chain_data[0]  = s2_q;
  assign chain_valid[0] = s2_valid_q;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    jia_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // Result stage.
  pipe_t fin;
  out_t  out_d, out_q;
  logic  out_valid_q;
  logic [63:0] quo, rmd, res;

  always_comb begin
    fin = chain_data[DivSteps];
    quo = fin.neg_q ? 64'(-fin.dvd) : fin.dvd;
    rmd = fin.neg_r ? 64'(-fin.rem) : fin.rem;
    res = fin.value;
    if (fin.status != ST_OK) begin
      res = '0;
    end else if ((fin.cmd == CMD_IDIV) || (fin.cmd == CMD_LDIV)) begin
      res = quo;
    end else if ((fin.cmd == CMD_IREM) || (fin.cmd == CMD_LREM)) begin
      res = rmd;
    end
    if (fin.kind == KIND_INT) begin
      res = {{32{res[31]}}, res[31:0]};
    end
    out_d.value  = res;
    out_d.kind   = fin.kind;
    out_d.status = fin.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_DIV0) |-> out_data_o.value == '0)
    else $error("divide by zero beat carries a nonzero value");

  a_bool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_BOOL) |-> out_data_o.value[63:1] == '0)
    else $error("boolean result is not 0 or 1");

  a_badop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_BADOP) |->
      (out_data_o.kind == KIND_INT && out_data_o.value == '0))
    else $error("unsupported opcode beat has wrong kind or value");

  a_int_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_INT) |->
      (out_data_o.value[63:32] == {32{out_data_o.value[31]}}))
    else $error("int result is not sign-extended");

endmodule
`default_nettype wire
